>>> design/sfcp_pkg.sv
`default_nettype none

package sfcp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_CH     = 4;
    localparam int CRC_W      = 16;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [MAX_CH*SAMPLE_W-1:0] samples;
        logic [CRC_W-1:0]           crc;
    } item_t;

    // CRC-16/MODBUS, one byte, reflected, LSB first
    function automatic logic [CRC_W-1:0] crc_update(
        input logic [CRC_W-1:0] crc,
        input logic [7:0]       data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/sfcp_crc_stage.sv
`default_nettype none

module sfcp_crc_stage #(
    parameter int BYTE_IDX = 0
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  sfcp_pkg::item_t   in_item,
    output logic              out_valid,
    input  wire               out_ready,
    output sfcp_pkg::item_t   out_item
);

    logic            valid_reg;
    sfcp_pkg::item_t item_reg;
    sfcp_pkg::item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next.samples = in_item.samples;
        item_next.crc     = sfcp_pkg::crc_update(in_item.crc,
                                                 in_item.samples[BYTE_IDX*8 +: 8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

>>> design/scope_frame_crc16_packer_core.sv
`default_nettype none

// Packs the first n 16-bit samples of one item into a frame of 2*n+2 bytes
// (n = CHANNELS clamped to 1..4): samples low byte first in channel order, then
// CRC-16/MODBUS low, high; tlast marks the final byte. The CRC runs through a
// pipeline of one register stage per data byte; an item passes through every stage
// and is then loaded into the output shift register. The single output byte port
// sets the sustained rate: while m_axis_tready stays high, frames go out back to
// back. Items are taken every cycle while the CRC pipeline has room.
module scope_frame_crc16_packer_core #(
    parameter int CHANNELS = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // sample_a, sample_b, sample_c, sample_d
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_byte
    output logic        m_axis_tlast    // last_byte
);

    localparam int N_USED    = (CHANNELS < 1) ? 1 :
                               ((CHANNELS > sfcp_pkg::MAX_CH) ? sfcp_pkg::MAX_CH : CHANNELS);
    localparam int N_BYTES   = 2 * N_USED;
    localparam int FRAME_LEN = N_BYTES + 2;
    localparam int FRAME_W   = FRAME_LEN * 8;
    localparam int CNT_W     = $clog2(FRAME_LEN);

    logic [N_BYTES:0] pipe_valid;
    logic [N_BYTES:0] pipe_ready;
    sfcp_pkg::item_t  pipe_item [0:N_BYTES];

    assign pipe_valid[0]        = s_axis_tvalid;
    assign s_axis_tready        = pipe_ready[0];
    assign pipe_item[0].samples = s_axis_tdata;
    assign pipe_item[0].crc     = sfcp_pkg::CRC_INIT;

    genvar g;
    generate
        for (g = 0; g < N_BYTES; g++)
        begin : g_crc
            sfcp_crc_stage #(
                .BYTE_IDX (g)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (pipe_valid[g]),
                .in_ready  (pipe_ready[g]),
                .in_item   (pipe_item[g]),
                .out_valid (pipe_valid[g+1]),
                .out_ready (pipe_ready[g+1]),
                .out_item  (pipe_item[g+1])
            );
        end
    endgenerate

    // output serialiser: shift register of the whole frame
    logic               out_valid_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               last;
    logic               take;
    logic               load;

    assign last          = (cnt_reg == CNT_W'(FRAME_LEN - 1));
    assign take          = out_valid_reg && m_axis_tready;
    assign pipe_ready[N_BYTES] = !out_valid_reg || (take && last);
    assign load          = pipe_valid[N_BYTES] && pipe_ready[N_BYTES];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = frame_reg[7:0];
    assign m_axis_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (take)
        begin
            out_valid_reg <= !last;
            cnt_reg       <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= {pipe_item[N_BYTES].crc,
                          pipe_item[N_BYTES].samples[N_BYTES*8-1:0]};
        end
        else if (take)
        begin
            frame_reg <= frame_reg >> 8;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cnt_reg <= CNT_W'(FRAME_LEN - 1)))
        else $error("byte count beyond frame length");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> out_valid_reg)
        else $error("frame cut short");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("byte count skipped");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid_reg && (cnt_reg == '0)))
        else $error("frame load did not start at first byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last) |-> !load)
        else $error("frame overwritten mid-way");
`endif

endmodule

`default_nettype wire
